// File: rtl/wsad_pkg.sv
package wsad_pkg;

	// Operand half width; only the low HALF_BITS bits of each input half are used
	localparam int HALF_BITS = 64;
	localparam int IN_BITS = 64;
	localparam int WORD_BITS = 2 * HALF_BITS;

	// Decimal digits of 2^(WORD_BITS-1), the largest magnitude
	localparam int DIGITS = (((WORD_BITS - 1) * 30103) / 100000) + 1;
	localparam int BCD_BITS = 4 * DIGITS;

	localparam int BIT_CNT_BITS = $clog2(WORD_BITS);
	localparam int DIG_CNT_BITS = $clog2(DIGITS);

	localparam logic [BIT_CNT_BITS-1:0] LAST_BIT = BIT_CNT_BITS'(WORD_BITS - 1);
	localparam logic [DIG_CNT_BITS-1:0] TOP_DIGIT = DIG_CNT_BITS'(DIGITS - 1);

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic negate;
		logic convert;
		logic skip;
		logic emit;
		logic last;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic top_zero;
	} status_t;

endpackage

// File: rtl/wsad_datapath.sv
module wsad_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wsad_pkg::cmd_t                cmd,
	output wsad_pkg::status_t             status,
	input  logic [wsad_pkg::IN_BITS-1:0]  a_upper,
	input  logic [wsad_pkg::IN_BITS-1:0]  a_lower,
	input  logic [wsad_pkg::IN_BITS-1:0]  b_upper,
	input  logic [wsad_pkg::IN_BITS-1:0]  b_lower,
	output logic [3:0]                    digit,
	output logic                          negative,
	output logic                          last_digit,
	output logic                          strobe
);

	logic [wsad_pkg::WORD_BITS-1:0] sum_q;
	logic [wsad_pkg::BCD_BITS-1:0]  bcd_q;
	logic [wsad_pkg::BCD_BITS-1:0]  bcd_adj;
	logic [wsad_pkg::WORD_BITS-1:0] op_a;
	logic [wsad_pkg::WORD_BITS-1:0] op_b;
	logic                           neg_q;
	logic [3:0]                     digit_q;
	logic                           negative_q;
	logic                           last_q;
	logic                           valid_q;

	// Assemble operands from the used low halves
	assign op_a = {a_upper[wsad_pkg::HALF_BITS-1:0], a_lower[wsad_pkg::HALF_BITS-1:0]};
	assign op_b = {b_upper[wsad_pkg::HALF_BITS-1:0], b_lower[wsad_pkg::HALF_BITS-1:0]};

	// Add 3 to every BCD digit of 5 or more before the shift
	always_comb begin
		for (int d = 0; d < wsad_pkg::DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	assign status.top_zero = (bcd_q[wsad_pkg::BCD_BITS-1 -: 4] == 4'd0);

	// Sum, magnitude and BCD conversion registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q <= op_a + op_b;
			bcd_q <= '0;
		end else if (cmd.negate) begin
			neg_q <= sum_q[wsad_pkg::WORD_BITS-1];
			if (sum_q[wsad_pkg::WORD_BITS-1]) begin
				sum_q <= ~sum_q + wsad_pkg::WORD_BITS'(1);
			end
		end else if (cmd.convert) begin
			bcd_q <= {bcd_adj[wsad_pkg::BCD_BITS-2:0], sum_q[wsad_pkg::WORD_BITS-1]};
			sum_q <= {sum_q[wsad_pkg::WORD_BITS-2:0], 1'b0};
		end else if (cmd.skip || cmd.emit) begin
			bcd_q <= {bcd_q[wsad_pkg::BCD_BITS-5:0], 4'd0};
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			digit_q    <= bcd_q[wsad_pkg::BCD_BITS-1 -: 4];
			negative_q <= neg_q;
			last_q     <= cmd.last;
		end
	end

	// Output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
		end
	end

	assign digit      = digit_q;
	assign negative   = negative_q;
	assign last_digit = last_q;
	assign strobe     = valid_q;

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> digit_q <= 4'd9)
		else $error("digit out of decimal range");

	a_run_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last_q |=> valid_q)
		else $error("digit run broken before last digit");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !valid_q)
		else $error("digit transfer right after load");

endmodule

// File: rtl/wsad_controller.sv
module wsad_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output wsad_pkg::cmd_t    cmd,
	input  wsad_pkg::status_t status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEG,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t                            state_q;
	logic [wsad_pkg::BIT_CNT_BITS-1:0] bit_cnt_q;
	logic [wsad_pkg::DIG_CNT_BITS-1:0] dig_cnt_q;
	logic                              skip_go;

	assign skip_go = status.top_zero && (dig_cnt_q != '0);

	// Decode commands from state
	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == ST_IDLE) && start;
		cmd.negate  = (state_q == ST_NEG);
		cmd.convert = (state_q == ST_CONV);
		cmd.skip    = (state_q == ST_SKIP) && skip_go;
		cmd.emit    = (state_q == ST_EMIT);
		cmd.last    = (state_q == ST_EMIT) && (dig_cnt_q == '0);
	end

	assign busy = (state_q != ST_IDLE);

	// Sequence add, sign fix, bit-serial conversion, zero skip and digit output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_NEG;
					end
				end
				ST_NEG: begin
					bit_cnt_q <= wsad_pkg::LAST_BIT;
					state_q   <= ST_CONV;
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - wsad_pkg::BIT_CNT_BITS'(1);
					if (bit_cnt_q == '0) begin
						dig_cnt_q <= wsad_pkg::TOP_DIGIT;
						state_q   <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (skip_go) begin
						dig_cnt_q <= dig_cnt_q - wsad_pkg::DIG_CNT_BITS'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					dig_cnt_q <= dig_cnt_q - wsad_pkg::DIG_CNT_BITS'(1);
					if (dig_cnt_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.last |=> !busy)
		else $error("still busy after last digit");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(cmd.emit && cmd.last))
		else $error("busy dropped before last digit");

endmodule

// File: rtl/wide_signed_add_to_decimal.sv
// Sequence: form the sign and magnitude, then bit-serial BCD shifting with one shift per sum
// bit, then suppression of leading zero digits, then one digit per cycle. The block takes a
// new item only when idle; busy drops in the cycle that carries the last digit.
// Reset: arst_n clears the controller and the strobe; the receiver cannot stall.
module wide_signed_add_to_decimal (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [wsad_pkg::IN_BITS-1:0] a_upper,
	input  logic [wsad_pkg::IN_BITS-1:0] a_lower,
	input  logic [wsad_pkg::IN_BITS-1:0] b_upper,
	input  logic [wsad_pkg::IN_BITS-1:0] b_lower,
	output logic [3:0]                   digit,
	output logic                         negative,
	output logic                         last_digit,
	output logic                         strobe
);

	wsad_pkg::cmd_t    cmd;
	wsad_pkg::status_t status;

	wsad_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	wsad_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.a_upper    (a_upper),
		.a_lower    (a_lower),
		.b_upper    (b_upper),
		.b_lower    (b_lower),
		.digit      (digit),
		.negative   (negative),
		.last_digit (last_digit),
		.strobe     (strobe)
	);

endmodule

// File: verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [wsad_pkg::WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic [3:0] digit;
		logic       negative;
		logic       last_digit;
	} digit_rec_t;

	localparam word_t MAX_POS = {1'b0, {(wsad_pkg::WORD_BITS-1){1'b1}}};
	localparam word_t MIN_NEG = {1'b1, {(wsad_pkg::WORD_BITS-1){1'b0}}};
	localparam word_t ALL_ONES = {wsad_pkg::WORD_BITS{1'b1}};
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_ITEMS = 90;

	// Decimal readout predictor and the digits still owed by the block
	class digit_scoreboard;
		digit_rec_t owed[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// Add the operands, split sign and magnitude, queue the digits
		function void note_operands(word_t a, word_t b);
			word_t sum;
			word_t mag;
			logic neg;
			digit_rec_t rec;
			logic [3:0] msd_first[$];
			sum = a + b;
			neg = sum[wsad_pkg::WORD_BITS-1];
			mag = neg ? (~sum + 1'b1) : sum;
			if (mag == '0)
				neg = 1'b0;
			do begin
				msd_first.push_front(4'(mag % 10));
				mag = mag / 10;
			end while (mag != '0);
			foreach (msd_first[i]) begin
				rec.digit = msd_first[i];
				rec.negative = neg;
				rec.last_digit = (i == msd_first.size() - 1);
				owed.push_back(rec);
			end
		endfunction

		// Compare one digit transfer with the oldest owed digit
		function void check_digit(logic [3:0] digit, logic negative, logic last_digit);
			digit_rec_t exp;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: unexpected digit transfer: digit %0d negative %0b last %0b",
					$time, digit, negative, last_digit);
				return;
			end
			exp = owed.pop_front();
			if (digit !== exp.digit) begin
				errors++;
				$display("%0t: digit mismatch: expected %0d actual %0d",
					$time, exp.digit, digit);
			end
			if (negative !== exp.negative) begin
				errors++;
				$display("%0t: negative mismatch: expected %0b actual %0b",
					$time, exp.negative, negative);
			end
			if (last_digit !== exp.last_digit) begin
				errors++;
				$display("%0t: last_digit mismatch: expected %0b actual %0b",
					$time, exp.last_digit, last_digit);
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [wsad_pkg::IN_BITS-1:0] a_upper;
	logic [wsad_pkg::IN_BITS-1:0] a_lower;
	logic [wsad_pkg::IN_BITS-1:0] b_upper;
	logic [wsad_pkg::IN_BITS-1:0] b_lower;
	logic [3:0]                   digit;
	logic                         negative;
	logic                         last_digit;
	logic                         strobe;
	int                           stall_count;

	digit_scoreboard sb = new();

	wide_signed_add_to_decimal dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.a_upper    (a_upper),
		.a_lower    (a_lower),
		.b_upper    (b_upper),
		.b_lower    (b_lower),
		.digit      (digit),
		.negative   (negative),
		.last_digit (last_digit),
		.strobe     (strobe)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Check every digit transfer
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_digit(digit, negative, last_digit);
	end

	// Abort when neither side transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("wide_signed_add_to_decimal test failed");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	function automatic word_t rand_word();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic word_t pow_ten(int k);
		word_t p;
		p = 1;
		repeat (k) p = p * 10;
		return p;
	endfunction

	// Pick an operand from a mix of shapes that spread the digit count
	function automatic word_t rand_operand();
		word_t v;
		int nbits;
		case ($urandom_range(0, 4))
			0: v = rand_word();
			1: begin
				nbits = $urandom_range(1, wsad_pkg::WORD_BITS - 1);
				v = rand_word() >> (wsad_pkg::WORD_BITS - nbits);
				if ($urandom_range(0, 1))
					v = ~v + 1'b1;
			end
			2: begin
				v = rand_word() >> $urandom_range(100, wsad_pkg::WORD_BITS - 1);
				v = $urandom_range(0, 1) ? (MIN_NEG + v) : (MAX_POS - v);
			end
			3: begin
				v = pow_ten($urandom_range(0, 38)) - $urandom_range(0, 1);
				if ($urandom_range(0, 1))
					v = ~v + 1'b1;
			end
			default: v = rand_word();
		endcase
		return v;
	endfunction

	// Hold start low for an idle gap whose length is given by n
	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Present one operand pair and hold it until the block takes it
	task automatic send_sum(word_t a, word_t b);
		@(negedge clk);
		start <= 1'b1;
		a_upper <= a[wsad_pkg::WORD_BITS-1 -: wsad_pkg::HALF_BITS];
		a_lower <= a[wsad_pkg::HALF_BITS-1:0];
		b_upper <= b[wsad_pkg::WORD_BITS-1 -: wsad_pkg::HALF_BITS];
		b_lower <= b[wsad_pkg::HALF_BITS-1:0];
		do @(posedge clk); while (busy);
		sb.note_operands(a, b);
	endtask

	task automatic run_phase(int count, int idle_pct);
		word_t a;
		word_t b;
		repeat (count) begin
			if ($urandom_range(1, 100) <= idle_pct)
				idle_cycles($urandom_range(1, 220));
			a = rand_operand();
			case ($urandom_range(0, 7))
				0: b = ~a + 1'b1;
				1: b = '0;
				default: b = rand_operand();
			endcase
			send_sum(a, b);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		a_upper = '0;
		a_lower = '0;
		b_upper = '0;
		b_lower = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: zero, sign edges, wrap, carries and digit counts
		send_sum('0, '0);
		send_sum(word_t'(1), ALL_ONES);
		send_sum(ALL_ONES, ALL_ONES);
		send_sum(MAX_POS, '0);
		send_sum(MAX_POS, word_t'(1));
		send_sum(MIN_NEG, '0);
		send_sum({2'b11, {(wsad_pkg::WORD_BITS-2){1'b0}}},
			{2'b11, {(wsad_pkg::WORD_BITS-2){1'b0}}});
		send_sum(MIN_NEG, MIN_NEG);
		send_sum(MAX_POS, MAX_POS);
		send_sum(word_t'(9), '0);
		send_sum(word_t'(10), '0);
		send_sum(pow_ten(38) - 1, '0);
		send_sum(~pow_ten(38) + 1'b1, '0);
		send_sum({{wsad_pkg::HALF_BITS{1'b0}}, {wsad_pkg::HALF_BITS{1'b1}}}, word_t'(1));
		send_sum({{wsad_pkg::HALF_BITS{1'b1}}, {wsad_pkg::HALF_BITS{1'b0}}}, '0);
		send_sum({1'b1, {(wsad_pkg::HALF_BITS-1){1'b0}}, {wsad_pkg::HALF_BITS{1'b0}}}, '0);
		send_sum({{wsad_pkg::HALF_BITS{1'b0}}, 1'b1, {(wsad_pkg::HALF_BITS-1){1'b0}}},
			{{wsad_pkg::HALF_BITS{1'b0}}, 1'b1, {(wsad_pkg::HALF_BITS-1){1'b0}}});
		send_sum({(wsad_pkg::WORD_BITS/2){2'b01}}, {(wsad_pkg::WORD_BITS/2){2'b10}});
		send_sum({(wsad_pkg::WORD_BITS/2){2'b10}}, '0);
		send_sum({(wsad_pkg::WORD_BITS/2){2'b01}}, '0);

		// Random: back to back, sparse sender, back to back again, mixed
		run_phase(PHASE_ITEMS, 0);
		run_phase(PHASE_ITEMS, 69);
		run_phase(PHASE_ITEMS, 0);
		run_phase(PHASE_ITEMS, 36);

		// Drain and let any stray digits show up
		@(negedge clk);
		start <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("wide_signed_add_to_decimal test passed");
		end else begin
			$display("wide_signed_add_to_decimal test failed");
		end
		$finish;
	end

endmodule
